>>> hdl/qn_pkg.sv
// qn_pkg: shared widths, types and a helper function for the quaternion nlerp block.
// Used by qn_isqrt, qn_norm and quaternion_nlerp. No dependencies.
package qn_pkg;

    localparam int FRAC_BITS = 14;   // fraction bits of blend and result
    localparam int CW    = 16;   // input component width
    localparam int BW    = 15;   // blend width
    localparam int QW    = 32;   // unit-quaternion component width, 30 fraction bits
    localparam int UW    = 31;   // inverse square root mantissa width
    localparam int LABW  = 33;   // squared length of an input quaternion
    localparam int LCW   = 62;   // squared length of the blended quaternion
    localparam int SQW   = 31;   // square of one input component

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [QW-1:0] t_qcomp;

    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> hdl/qn_isqrt.sv
// qn_isqrt: pipelined inverse square root, one result bit per stage, exact round to nearest.
// Depends on qn_pkg. A side payload travels along.
module qn_isqrt #(
    parameter int LW = 33,
    parameter int PW = 1,
    localparam int K  = (LW + 1) / 2,
    localparam int GW = $clog2(K + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LW-1:0]          i_len,
    input  logic [PW-1:0]          i_side,
    output logic                   o_valid,
    output logic [qn_pkg::UW-1:0]  o_u,
    output logic [GW-1:0]          o_g,
    output logic [PW-1:0]          o_side
);

    localparam int LMW = 2 * K;
    localparam int SW  = 2 * K + 66;
    localparam int E   = 60 + 2 * K;
    localparam int NST = qn_pkg::UW;
    localparam logic signed [SW-1:0] LIMIT = $signed({{(SW-1){1'b0}}, 1'b1} << E);

    logic [6:0]     w_b;
    logic [GW-1:0]  w_g;
    logic [6:0]     w_sh;
    logic [LMW-1:0] w_lm;

    logic signed [SW-1:0]    r_s    [NST];
    logic signed [SW-1:0]    r_t    [NST];
    logic [LMW-1:0]          r_lm   [NST];
    logic [qn_pkg::UW-1:0]   r_u    [NST+1];
    logic [GW-1:0]           r_g    [NST+1];
    logic [PW-1:0]           r_side [NST+1];
    logic                    r_vld  [NST+1];

    // normalize the length to a fixed even bit range
    always_comb begin
        w_b  = qn_pkg::bit_len(64'(i_len));
        w_g  = GW'((w_b + 7'd1) >> 1);
        w_sh = 7'(LMW) - 7'({w_g, 1'b0});
        w_lm = LMW'(i_len) << w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lm[0]   <= w_lm;
            r_s[0]    <= $signed(SW'(w_lm));
            r_t[0]    <= -$signed(SW'(w_lm));
            r_u[0]    <= '0;
            r_g[0]    <= w_g;
            r_side[0] <= i_side;
        end
    end

    // stage j decides bit KB: S = w^2*L, T = w*L, w = 2u-1
    for (genvar j = 0; j < NST; j++) begin : g_step
        localparam int KB = NST - 1 - j;
        logic signed [SW-1:0] w_lme;
        logic signed [SW-1:0] w_test;
        logic                 w_take;

        always_comb begin
            w_lme  = $signed(SW'(r_lm[j]));
            w_test = r_s[j] + (r_t[j] <<< (KB + 2)) + (w_lme <<< (2 * KB + 2));
            w_take = (w_test <= LIMIT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_u[j+1]    <= r_u[j] | (qn_pkg::UW'(w_take) << KB);
                r_g[j+1]    <= r_g[j];
                r_side[j+1] <= r_side[j];
            end
        end

        if (j < NST - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[j+1]  <= w_take ? w_test : r_s[j];
                    r_t[j+1]  <= w_take ? (r_t[j] + (w_lme <<< (KB + 1))) : r_t[j];
                    r_lm[j+1] <= r_lm[j];
                end
            end
        end
    end

    assign o_valid = r_vld[NST];
    assign o_u     = r_u[NST];
    assign o_g     = r_g[NST];
    assign o_side  = r_side[NST];

endmodule

>>> hdl/qn_norm.sv
// qn_norm: scales four components by an inverse square root and rounds the shift.
// Depends on qn_pkg. Two register stages, a side payload travels along.
module qn_norm #(
    parameter int VW  = 16,
    parameter int OW  = 32,
    parameter int SHW = 5,
    parameter int PW  = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [VW-1:0]   i_v [4],
    input  logic [qn_pkg::UW-1:0]  i_u,
    input  logic [SHW-1:0]         i_shift,
    input  logic [PW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [OW-1:0]   o_q [4],
    output logic [PW-1:0]          o_side
);

    localparam int PRW = VW + qn_pkg::UW + 1;

    logic signed [PRW-1:0] r_p [4];
    logic [SHW-1:0]        r_sh;
    logic [PW-1:0]         r_side1;
    logic                  r_vld1;
    logic signed [OW-1:0]  r_q [4];
    logic [PW-1:0]         r_side2;
    logic                  r_vld2;

    logic [PRW-1:0] w_mag  [4];
    logic [PRW:0]   w_half;
    logic [PRW:0]   w_rnd  [4];
    logic signed [OW-1:0] w_q [4];

    always_comb begin
        w_half = (r_sh == '0) ? '0 : ((PRW + 1)'(1) << (r_sh - SHW'(1)));
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = r_p[i][PRW-1] ? PRW'(-r_p[i]) : PRW'(r_p[i]);
            w_rnd[i] = ({1'b0, w_mag[i]} + w_half) >> r_sh;
            w_q[i]   = r_p[i][PRW-1] ? -$signed(OW'(w_rnd[i])) : $signed(OW'(w_rnd[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p[i] <= i_v[i] * $signed({1'b0, i_u});
                r_q[i] <= w_q[i];
            end
            r_sh    <= i_shift;
            r_side1 <= i_side;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_vld2;
    assign o_q     = r_q;
    assign o_side  = r_side2;

endmodule

>>> hdl/quaternion_nlerp.sv
// quaternion_nlerp: top level, normalized linear interpolation of two quaternions.
// Depends on qn_pkg, qn_isqrt and qn_norm.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | i_valid / o_ready   | i_a_x..i_a_w, i_b_x..i_b_w, i_blend
//  output  | o_valid / i_ready   | o_r_x..o_r_w, o_flipped, o_degenerate
//
// One transaction enters per cycle unless a result waits on the output.
// Most of the pipeline is the inverse square root pipelines (both inputs side by side,
// then the blended sum), one result bit decided per stage.
// The whole pipeline holds while a result waits on the output; no transaction
// is lost or repeated. Reset clears the valid bits only.
module quaternion_nlerp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [15:0]         i_a_x,
    input  logic signed [15:0]         i_a_y,
    input  logic signed [15:0]         i_a_z,
    input  logic signed [15:0]         i_a_w,
    input  logic signed [15:0]         i_b_x,
    input  logic signed [15:0]         i_b_y,
    input  logic signed [15:0]         i_b_z,
    input  logic signed [15:0]         i_b_w,
    input  logic [14:0]                i_blend,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [15:0]         o_r_x,
    output logic signed [15:0]         o_r_y,
    output logic signed [15:0]         o_r_z,
    output logic signed [15:0]         o_r_w,
    output logic                       o_flipped,
    output logic                       o_degenerate
);

    localparam int FRAC_BITS = qn_pkg::FRAC_BITS;
    localparam int CW   = qn_pkg::CW;
    localparam int QW   = qn_pkg::QW;
    localparam int BW   = qn_pkg::BW;
    localparam int GWA  = $clog2((qn_pkg::LABW + 1) / 2 + 1);
    localparam int GWC  = $clog2((qn_pkg::LCW + 1) / 2 + 1);
    localparam int SHC  = 6;
    localparam int OMW  = FRAC_BITS + 1;
    localparam int MPW  = QW + FRAC_BITS + 2;
    localparam int MW   = MPW + 1;
    localparam int PWA  = 4 * CW + 1;
    localparam int PWB  = 4 * CW + BW;
    localparam int PWC  = 4 * QW + 2;
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [MW:0] HALF_F = (MW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [QW-1:0] ONE_Q = $signed(ONE64[QW-1:0]);

    logic w_en;

    // stage 1: capture and square
    qn_pkg::t_comp        w_a [4];
    qn_pkg::t_comp        w_b [4];
    logic signed [31:0]   w_pa [4];
    logic signed [31:0]   w_pb [4];
    logic                 r1_vld;
    qn_pkg::t_comp        r1_a [4];
    qn_pkg::t_comp        r1_b [4];
    logic [BW-1:0]        r1_t;
    logic [qn_pkg::SQW-1:0] r1_sqa [4];
    logic [qn_pkg::SQW-1:0] r1_sqb [4];

    // stage 2: squared lengths
    logic [qn_pkg::LABW-1:0] w_la;
    logic [qn_pkg::LABW-1:0] w_lb;
    logic                 r2_vld;
    logic [qn_pkg::LABW-1:0] r2_la;
    logic [qn_pkg::LABW-1:0] r2_lb;
    logic [PWA-1:0]       r2_sidea;
    logic [PWB-1:0]       r2_sideb;

    // inverse square roots of the inputs
    logic                 w_ia_vld;
    logic                 w_ib_vld;
    logic [qn_pkg::UW-1:0] w_ua;
    logic [qn_pkg::UW-1:0] w_ub;
    logic [GWA-1:0]       w_ga;
    logic [GWA-1:0]       w_gb;
    logic [PWA-1:0]       w_sidea;
    logic [PWB-1:0]       w_sideb;
    qn_pkg::t_comp        w_va [4];
    qn_pkg::t_comp        w_vb [4];

    // normalized inputs
    logic                 w_na_vld;
    logic                 w_nb_vld;
    qn_pkg::t_qcomp       w_q1 [4];
    qn_pkg::t_qcomp       w_q2 [4];
    logic [0:0]           w_na_side;
    logic [BW-1:0]        w_nb_side;

    // dot product, blend
    logic                 r3_vld;
    logic signed [63:0]   r3_dp [4];
    qn_pkg::t_qcomp       r3_q1 [4];
    qn_pkg::t_qcomp       r3_q2 [4];
    logic [BW-1:0]        r3_t;
    logic                 r3_zero;

    logic signed [65:0]   w_dot;
    logic                 w_flip;
    logic [BW-1:0]        w_tc;
    logic [31:0]          w_omt32;
    logic                 r4_vld;
    qn_pkg::t_qcomp       r4_q1 [4];
    qn_pkg::t_qcomp       r4_qf [4];
    logic [BW-1:0]        r4_tc;
    logic [OMW-1:0]       r4_omt;
    logic                 r4_flip;
    logic                 r4_zero;

    logic                 r5_vld;
    logic signed [MPW-1:0] r5_m1 [4];
    logic signed [MPW-1:0] r5_m2 [4];
    logic                 r5_flip;
    logic                 r5_zero;

    logic signed [MW-1:0] w_m   [4];
    logic [MW-1:0]        w_mmag [4];
    logic [MW:0]          w_mrnd [4];
    qn_pkg::t_qcomp       w_c   [4];
    logic                 r6_vld;
    qn_pkg::t_qcomp       r6_c [4];
    logic                 r6_flip;
    logic                 r6_zero;

    logic                 r7_vld;
    logic [qn_pkg::LCW-1:0] r7_sq [4];
    qn_pkg::t_qcomp       r7_c [4];
    logic                 r7_flip;
    logic                 r7_zero;

    logic [qn_pkg::LCW-1:0] w_lc;
    logic                 r8_vld;
    logic [qn_pkg::LCW-1:0] r8_lc;
    logic [PWC-1:0]       r8_side;

    // inverse square root of the blend, final scaling
    logic                 w_ic_vld;
    logic [qn_pkg::UW-1:0] w_uc;
    logic [GWC-1:0]       w_gc;
    logic [PWC-1:0]       w_sidec;
    qn_pkg::t_qcomp       w_vc [4];
    logic [SHC-1:0]       w_shc;
    logic                 w_nc_vld;
    qn_pkg::t_qcomp       w_rc [4];
    logic [1:0]           w_nc_side;

    logic                 r_out_vld;
    logic signed [15:0]   r_out_q [4];
    logic                 r_out_flip;
    logic                 r_out_deg;
    qn_pkg::t_qcomp       w_cl [4];

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // ---- stage 1
    always_comb begin
        w_a[0] = i_a_x; w_a[1] = i_a_y; w_a[2] = i_a_z; w_a[3] = i_a_w;
        w_b[0] = i_b_x; w_b[1] = i_b_y; w_b[2] = i_b_z; w_b[3] = i_b_w;
        for (int i = 0; i < 4; i++) begin
            w_pa[i] = w_a[i] * w_a[i];
            w_pb[i] = w_b[i] * w_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_a[i]   <= w_a[i];
                r1_b[i]   <= w_b[i];
                r1_sqa[i] <= w_pa[i][qn_pkg::SQW-1:0];
                r1_sqb[i] <= w_pb[i][qn_pkg::SQW-1:0];
            end
            r1_t <= i_blend;
        end
    end

    // ---- stage 2
    always_comb begin
        w_la = qn_pkg::LABW'(r1_sqa[0]) + qn_pkg::LABW'(r1_sqa[1])
             + qn_pkg::LABW'(r1_sqa[2]) + qn_pkg::LABW'(r1_sqa[3]);
        w_lb = qn_pkg::LABW'(r1_sqb[0]) + qn_pkg::LABW'(r1_sqb[1])
             + qn_pkg::LABW'(r1_sqb[2]) + qn_pkg::LABW'(r1_sqb[3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_la    <= w_la;
            r2_lb    <= w_lb;
            r2_sidea <= {r1_a[0], r1_a[1], r1_a[2], r1_a[3],
                         (w_la == '0) || (w_lb == '0)};
            r2_sideb <= {r1_b[0], r1_b[1], r1_b[2], r1_b[3], r1_t};
        end
    end

    qn_isqrt #(.LW(qn_pkg::LABW), .PW(PWA)) u_isqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_len   (r2_la),
        .i_side  (r2_sidea),
        .o_valid (w_ia_vld),
        .o_u     (w_ua),
        .o_g     (w_ga),
        .o_side  (w_sidea)
    );

    qn_isqrt #(.LW(qn_pkg::LABW), .PW(PWB)) u_isqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_len   (r2_lb),
        .i_side  (r2_sideb),
        .o_valid (w_ib_vld),
        .o_u     (w_ub),
        .o_g     (w_gb),
        .o_side  (w_sideb)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_va[i] = w_sidea[1 + CW * (3 - i) +: CW];
            w_vb[i] = w_sideb[BW + CW * (3 - i) +: CW];
        end
    end

    qn_norm #(.VW(CW), .OW(QW), .SHW(GWA), .PW(1)) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ia_vld),
        .i_v     (w_va),
        .i_u     (w_ua),
        .i_shift (w_ga - GWA'(1)),
        .i_side  (w_sidea[0:0]),
        .o_valid (w_na_vld),
        .o_q     (w_q1),
        .o_side  (w_na_side)
    );

    qn_norm #(.VW(CW), .OW(QW), .SHW(GWA), .PW(BW)) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ib_vld),
        .i_v     (w_vb),
        .i_u     (w_ub),
        .i_shift (w_gb - GWA'(1)),
        .i_side  (w_sideb[BW-1:0]),
        .o_valid (w_nb_vld),
        .o_q     (w_q2),
        .o_side  (w_nb_side)
    );

    // ---- dot product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r3_dp[i] <= w_q1[i] * w_q2[i];
                r3_q1[i] <= w_q1[i];
                r3_q2[i] <= w_q2[i];
            end
            r3_t    <= w_nb_side;
            r3_zero <= w_na_side[0];
        end
    end

    always_comb begin
        w_dot = 66'(r3_dp[0]) + 66'(r3_dp[1]) + 66'(r3_dp[2]) + 66'(r3_dp[3]);
        w_flip = w_dot[65];
        w_tc = ({17'd0, r3_t} > ONE64[31:0]) ? ONE64[BW-1:0] : r3_t;
        w_omt32 = ONE64[31:0] - {17'd0, w_tc};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r4_q1[i] <= r3_q1[i];
                r4_qf[i] <= w_flip ? -r3_q2[i] : r3_q2[i];
            end
            r4_tc   <= w_tc;
            r4_omt  <= w_omt32[OMW-1:0];
            r4_flip <= w_flip;
            r4_zero <= r3_zero;
        end
    end

    // ---- blend
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r5_m1[i] <= r4_q1[i] * $signed({1'b0, r4_omt});
                r5_m2[i] <= r4_qf[i] * $signed({1'b0, r4_tc});
            end
            r5_flip <= r4_flip;
            r5_zero <= r4_zero;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_m[i]    = MW'(r5_m1[i]) + MW'(r5_m2[i]);
            w_mmag[i] = w_m[i][MW-1] ? MW'(-w_m[i]) : MW'(w_m[i]);
            w_mrnd[i] = ({1'b0, w_mmag[i]} + HALF_F) >> FRAC_BITS;
            w_c[i]    = w_m[i][MW-1] ? -$signed(QW'(w_mrnd[i])) : $signed(QW'(w_mrnd[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_c    <= w_c;
            r6_flip <= r5_flip;
            r6_zero <= r5_zero;
        end
    end

    // ---- squared length of the blend
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r7_sq[i] <= qn_pkg::LCW'(64'(r6_c[i]) * 64'(r6_c[i]));
            end
            r7_c    <= r6_c;
            r7_flip <= r6_flip;
            r7_zero <= r6_zero;
        end
    end

    assign w_lc = r7_sq[0] + r7_sq[1] + r7_sq[2] + r7_sq[3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_lc   <= w_lc;
            r8_side <= {r7_c[0], r7_c[1], r7_c[2], r7_c[3],
                        r7_flip, r7_zero || (w_lc == '0)};
        end
    end

    qn_isqrt #(.LW(qn_pkg::LCW), .PW(PWC)) u_isqrt_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_vld),
        .i_len   (r8_lc),
        .i_side  (r8_side),
        .o_valid (w_ic_vld),
        .o_u     (w_uc),
        .o_g     (w_gc),
        .o_side  (w_sidec)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_vc[i] = w_sidec[2 + QW * (3 - i) +: QW];
        end
        w_shc = SHC'(7'd29 + 7'(w_gc) - 7'(FRAC_BITS));
    end

    qn_norm #(.VW(QW), .OW(QW), .SHW(SHC), .PW(2)) u_norm_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ic_vld),
        .i_v     (w_vc),
        .i_u     (w_uc),
        .i_shift (w_shc),
        .i_side  (w_sidec[1:0]),
        .o_valid (w_nc_vld),
        .o_q     (w_rc),
        .o_side  (w_nc_side)
    );

    // ---- clamp and output register
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (w_rc[i] > ONE_Q) begin
                w_cl[i] = ONE_Q;
            end else if (w_rc[i] < -ONE_Q) begin
                w_cl[i] = -ONE_Q;
            end else begin
                w_cl[i] = w_rc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_nc_side[0]) begin
                r_out_q[0] <= '0;
                r_out_q[1] <= '0;
                r_out_q[2] <= '0;
                r_out_q[3] <= $signed(ONE64[15:0]);
                r_out_flip <= 1'b0;
                r_out_deg  <= 1'b1;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    r_out_q[i] <= w_cl[i][15:0];
                end
                r_out_flip <= w_nc_side[1];
                r_out_deg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld    <= i_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= w_na_vld && w_nb_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r_out_vld <= w_nc_vld;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_r_x        = r_out_q[0];
    assign o_r_y        = r_out_q[1];
    assign o_r_z        = r_out_q[2];
    assign o_r_w        = r_out_q[3];
    assign o_flipped    = r_out_flip;
    assign o_degenerate = r_out_deg;

endmodule

>>> hdl/qn_check.sv
// qn_check: port-level checks for quaternion_nlerp, attached with bind.
// Depends on nothing but the ports of quaternion_nlerp.
module qn_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic signed [15:0] i_a_x,
    input logic signed [15:0] i_a_y,
    input logic signed [15:0] i_a_z,
    input logic signed [15:0] i_a_w,
    input logic signed [15:0] i_b_x,
    input logic signed [15:0] i_b_y,
    input logic signed [15:0] i_b_z,
    input logic signed [15:0] i_b_w,
    input logic [14:0]        i_blend,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_r_x,
    input logic signed [15:0] o_r_y,
    input logic signed [15:0] o_r_z,
    input logic signed [15:0] o_r_w,
    input logic               o_flipped,
    input logic               o_degenerate
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r_x) && $stable(o_r_y)
            && $stable(o_r_z) && $stable(o_r_w) && $stable(o_flipped)
            && $stable(o_degenerate))
        else $error("stalled result changed");

    // input side is ready whenever the output slot is free or drains
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output slot");

    // degenerate results carry no vector part and no flip
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_r_x == 16'sd0 && o_r_y == 16'sd0
            && o_r_z == 16'sd0 && !o_flipped)
        else $error("degenerate result not identity");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("valid result right after reset");

endmodule

bind quaternion_nlerp qn_check u_qn_check (.*);
